>>> rtl/core/cfp_pkg.sv
// Package for the circular FIFO with peek: command and status codes,
// register indexes, field widths and the item width mask function.
// Used by the top level and the testbench; depends on nothing.
package cfp_pkg;

  localparam int DataW      = 64;
  localparam int CapW       = 9;
  localparam int SumW       = CapW + 1;
  localparam int ItemBytesW = 4;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = CapW;
  localparam int CmdW       = 2;
  localparam int StatusW    = 2;

  typedef enum logic [CmdW-1:0] {
    CmdPut   = 2'd0,
    CmdGet   = 2'd1,
    CmdRead  = 2'd2,
    CmdFlush = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StEmpty  = 2'd2,
    StBadPos = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] CfgCapacity  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgItemBytes = 1'd1;

  localparam logic [CapW-1:0]       CapacityReset  = 9'd256;
  localparam logic [ItemBytesW-1:0] ItemBytesReset = 4'd8;

  // Byte mask for an item width; zero bytes counts as one, eight or more as all.
  function automatic logic [DataW-1:0] item_mask(input logic [ItemBytesW-1:0] nbytes);
    logic [ItemBytesW-1:0] eff;
    logic [DataW-1:0]      mask;
    eff = (nbytes == '0) ? ItemBytesW'(1) : nbytes;
    for (int i = 0; i < DataW / 8; i++) begin
      mask[i*8 +: 8] = (ItemBytesW'(i) < eff) ? 8'hff : 8'h00;
    end
    return mask;
  endfunction

endpackage

>>> rtl/core/cfp_ram.sv
// Generic single-port RAM with a registered read port.
// Used for the item storage of the circular FIFO; depends on nothing.
module cfp_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/circular_fifo_with_peek.sv
// Top level of the circular FIFO with peek: command decode, pointers,
// result pipeline and a small remainder unit. Depends on cfp_pkg and cfp_ram.
//
// The block takes one command per clock cycle while in_stall_o is low and
// returns one result word for each: the storage RAM read is registered and
// the result sits in an output register. Two cases stall the input while the
// ten steps of a shared shift-and-subtract remainder unit run: after a
// capacity write the head index is reduced modulo the new capacity, and a
// read whose slot wraps the ring more than once (only when the count exceeds
// a lowered capacity) computes its slot index before it is accepted.
module circular_fifo_with_peek #(
  parameter int DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cfp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [cfp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [cfp_pkg::CmdW-1:0]        cmd_i,
  input  logic [cfp_pkg::DataW-1:0]       data_i,
  input  logic [cfp_pkg::CapW-1:0]        position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cfp_pkg::StatusW-1:0]     status_o,
  output logic [cfp_pkg::DataW-1:0]       item_out_o,
  output logic [cfp_pkg::CapW-1:0]        occupancy_o
);

  localparam int AddrW    = $clog2(DEPTH);
  localparam int CapLimit = (DEPTH < 511) ? DEPTH : 511;
  localparam int CapW     = cfp_pkg::CapW;
  localparam int SumW     = cfp_pkg::SumW;
  localparam int DivW     = SumW + CapW;
  localparam logic [CapW-1:0] CapMax = CapW'(CapLimit);

  logic [CapW-1:0]                 capacity_q;
  logic [cfp_pkg::ItemBytesW-1:0]  item_bytes_q;
  logic [CapW-1:0]                 head_q, head_d;
  logic [CapW-1:0]                 h_q, h_d;
  logic [CapW-1:0]                 fill_q, fill_d;

  logic [CapW-1:0]                 cap;
  logic                            cap_write;
  logic                            in_acc;
  logic                            pipe_ready;

  logic                            norm_pending_q;
  logic                            md_busy_q;
  logic                            md_is_read_q;
  logic [SumW-1:0]                 md_x_q;
  logic [3:0]                      md_k_q;
  logic [DivW-1:0]                 md_div;
  logic [SumW-1:0]                 md_x_next;
  logic                            md_start_norm;
  logic                            md_start_read;
  logic                            rd_idx_valid_q;
  logic [CapW-1:0]                 rd_idx_q;

  logic                            s1_valid_q;
  logic [cfp_pkg::StatusW-1:0]     s1_status_q;
  logic [CapW-1:0]                 s1_occ_q;
  logic                            s1_has_item_q;
  logic                            s1_adv;

  logic                            out_valid_q;
  logic [cfp_pkg::StatusW-1:0]     out_status_q;
  logic [cfp_pkg::DataW-1:0]       out_item_q;
  logic [CapW-1:0]                 out_occ_q;

  cfp_pkg::status_e                st;
  logic [CapW-1:0]                 occ;
  logic                            has_item;
  logic                            ram_en;
  logic                            ram_we;
  logic [CapW-1:0]                 idx;
  logic [cfp_pkg::DataW-1:0]       ram_rdata;
  logic [cfp_pkg::DataW-1:0]       mask;

  logic [SumW-1:0]                 put_sum;
  logic [SumW-1:0]                 get_next;
  logic [CapW-1:0]                 pos_m1;
  logic [SumW-1:0]                 rd_sum;
  logic [SumW-1:0]                 rd_sub;
  logic                            rd_ok;
  logic                            rd_need_mod;

  always_comb begin
    cap = (capacity_q == '0) ? CapW'(1) : capacity_q;
    if (cap > CapMax) begin
      cap = CapMax;
    end
  end

  assign mask      = cfp_pkg::item_mask(item_bytes_q);
  assign cap_write = cfg_we_i && (cfg_index_i == cfp_pkg::CfgCapacity);

  assign put_sum  = {1'b0, h_q} + {1'b0, fill_q};
  assign get_next = {1'b0, h_q} + SumW'(1);
  assign pos_m1   = position_i - CapW'(1);
  assign rd_sum   = {1'b0, h_q} + {1'b0, pos_m1};
  assign rd_sub   = rd_sum - {1'b0, cap};
  assign rd_ok    = (fill_q != '0) && (position_i != '0) && (position_i <= fill_q);
  assign rd_need_mod = rd_ok && (rd_sum >= {1'b0, cap}) && (rd_sub >= {1'b0, cap});

  always_comb begin
    st       = cfp_pkg::StOk;
    occ      = fill_q;
    has_item = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    idx      = h_q;
    fill_d   = fill_q;
    head_d   = head_q;
    h_d      = h_q;
    unique case (cfp_pkg::cmd_e'(cmd_i))
      cfp_pkg::CmdPut: begin
        if (fill_q >= cap) begin
          st = cfp_pkg::StFull;
        end else begin
          ram_en = 1'b1;
          ram_we = 1'b1;
          idx    = (put_sum >= {1'b0, cap}) ? CapW'(put_sum - {1'b0, cap}) : put_sum[CapW-1:0];
          fill_d = fill_q + CapW'(1);
        end
        occ = fill_d;
      end
      cfp_pkg::CmdGet: begin
        if (fill_q == '0) begin
          st = cfp_pkg::StEmpty;
        end else begin
          ram_en   = 1'b1;
          has_item = 1'b1;
          idx      = h_q;
          h_d      = (get_next >= {1'b0, cap}) ? '0 : get_next[CapW-1:0];
          head_d   = h_d;
          fill_d   = fill_q - CapW'(1);
        end
        occ = fill_d;
      end
      cfp_pkg::CmdRead: begin
        if (fill_q == '0) begin
          st = cfp_pkg::StEmpty;
        end else if (!rd_ok) begin
          st = cfp_pkg::StBadPos;
        end else begin
          ram_en   = 1'b1;
          has_item = 1'b1;
          if (rd_sum < {1'b0, cap}) begin
            idx = rd_sum[CapW-1:0];
          end else if (!rd_need_mod) begin
            idx = rd_sub[CapW-1:0];
          end else begin
            idx = rd_idx_q;
          end
        end
      end
      cfp_pkg::CmdFlush: begin
        fill_d = '0;
        head_d = '0;
        h_d    = '0;
      end
      default: begin
        st = cfp_pkg::StOk;
      end
    endcase
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign pipe_ready = !s1_valid_q || s1_adv;

  assign in_stall_o = !pipe_ready || norm_pending_q || md_busy_q ||
                      ((cfp_pkg::cmd_e'(cmd_i) == cfp_pkg::CmdRead) && rd_need_mod &&
                       !rd_idx_valid_q);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign md_start_norm = norm_pending_q && !md_busy_q && !cap_write;
  assign md_start_read = !norm_pending_q && !md_busy_q && !cap_write && in_valid_i &&
                         (cfp_pkg::cmd_e'(cmd_i) == cfp_pkg::CmdRead) && rd_need_mod &&
                         !rd_idx_valid_q;

  assign md_div    = DivW'(cap) << md_k_q;
  assign md_x_next = (DivW'(md_x_q) >= md_div) ? (md_x_q - md_div[SumW-1:0]) : md_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= cfp_pkg::CapacityReset;
      item_bytes_q <= cfp_pkg::ItemBytesReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == cfp_pkg::CfgCapacity) begin
        capacity_q <= cfg_data_i;
      end else begin
        item_bytes_q <= cfg_data_i[cfp_pkg::ItemBytesW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      h_q    <= '0;
      fill_q <= '0;
    end else if (in_acc) begin
      head_q <= head_d;
      h_q    <= h_d;
      fill_q <= fill_d;
    end else if (md_busy_q && (md_k_q == '0) && !md_is_read_q && !cap_write) begin
      h_q <= md_x_next[CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_pending_q <= 1'b0;
      md_busy_q      <= 1'b0;
      md_is_read_q   <= 1'b0;
      md_x_q         <= '0;
      md_k_q         <= '0;
      rd_idx_valid_q <= 1'b0;
      rd_idx_q       <= '0;
    end else if (cap_write) begin
      norm_pending_q <= 1'b1;
      md_busy_q      <= 1'b0;
      rd_idx_valid_q <= 1'b0;
    end else if (md_busy_q) begin
      md_x_q <= md_x_next;
      md_k_q <= md_k_q - 4'd1;
      if (md_k_q == '0) begin
        md_busy_q <= 1'b0;
        if (md_is_read_q) begin
          rd_idx_q       <= md_x_next[CapW-1:0];
          rd_idx_valid_q <= 1'b1;
        end else begin
          norm_pending_q <= 1'b0;
        end
      end
    end else if (md_start_norm) begin
      md_busy_q    <= 1'b1;
      md_is_read_q <= 1'b0;
      md_x_q       <= {1'b0, head_q};
      md_k_q       <= 4'(SumW - 1);
    end else if (md_start_read) begin
      md_busy_q    <= 1'b1;
      md_is_read_q <= 1'b1;
      md_x_q       <= rd_sum;
      md_k_q       <= 4'(SumW - 1);
    end else if (in_acc) begin
      rd_idx_valid_q <= 1'b0;
    end
  end

  cfp_ram #(
    .Width(cfp_pkg::DataW),
    .Depth(DEPTH)
  ) u_storage (
    .clk_i  (clk_i),
    .en_i   (in_acc && ram_en),
    .we_i   (ram_we),
    .addr_i (AddrW'(idx)),
    .wdata_i(data_i & mask),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_status_q   <= st;
      s1_occ_q      <= occ;
      s1_has_item_q <= has_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_occ_q    <= s1_occ_q;
      out_item_q   <= s1_has_item_q ? (ram_rdata & mask) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign item_out_o  = out_item_q;
  assign occupancy_o = out_occ_q;

endmodule

>>> tb/sv/circular_fifo_with_peek_test.sv
// Self-checking testbench for circular_fifo_with_peek: directed and random command words,
// with random idle cycles on both sides and several capacity and item width settings.
// Depends on cfp_pkg and the circular_fifo_with_peek RTL.
module circular_fifo_with_peek_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DataW    = cfp_pkg::DataW;
  localparam int CapW     = cfp_pkg::CapW;
  localparam int CfgIdxW  = cfp_pkg::CfgIdxW;
  localparam int CfgDataW = cfp_pkg::CfgDataW;
  localparam int CmdW     = cfp_pkg::CmdW;
  localparam int StatusW  = cfp_pkg::StatusW;

  localparam int unsigned RingDepth  = 256;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseCap   [NumPhases] = '{256, 4, 1, 0, 511, 37, 2, 300, 255, 8};
  localparam int unsigned PhaseBytes [NumPhases] = '{8, 1, 0, 15, 8, 5, 3, 2, 9, 7};
  localparam int unsigned PhasePut   [NumPhases] = '{70, 45, 50, 40, 92, 50, 55, 60, 40, 50};
  localparam int unsigned PhaseItems [NumPhases] =
    '{180, 180, 180, 180, 320, 180, 180, 180, 150, 150};

  typedef struct {
    cfp_pkg::status_e status;
    logic [DataW-1:0] item;
    logic [CapW-1:0]  occ;
  } fifo_result_t;

  class fifo_scoreboard;
    logic [DataW-1:0]  ring [RingDepth];
    bit                written [RingDepth];
    int unsigned       head_idx;
    int unsigned       count;
    logic [CapW-1:0]   cap_reg;
    logic [3:0]        bytes_reg;
    fifo_result_t      expected_q [$];
    int unsigned       errors;
    int unsigned       words_in;
    int unsigned       status_seen [4];

    function new();
      for (int i = 0; i < RingDepth; i++) begin
        ring[i] = '0;
        written[i] = 1'b0;
      end
      head_idx = 0;
      count = 0;
      cap_reg = cfp_pkg::CapacityReset;
      bytes_reg = cfp_pkg::ItemBytesReset;
      errors = 0;
      words_in = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    function int unsigned eff_cap();
      int unsigned c;
      c = cap_reg;
      if (c == 0) c = 1;
      if (c > RingDepth) c = RingDepth;
      return c;
    endfunction

    function logic [DataW-1:0] width_mask();
      int unsigned b;
      b = (bytes_reg == 0) ? 1 : bytes_reg;
      if (b >= 8) return '1;
      return (64'd1 << (8 * b)) - 64'd1;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
      if (idx == cfp_pkg::CfgCapacity) cap_reg = v;
      else if (idx == cfp_pkg::CfgItemBytes) bytes_reg = v[3:0];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // True when the command would read a ring entry that was never written.
    function bit touches_unwritten(cfp_pkg::cmd_e c, logic [CapW-1:0] p);
      int unsigned cap;
      int unsigned h;
      cap = eff_cap();
      h = head_idx % cap;
      if (count == 0) return 1'b0;
      if (c == cfp_pkg::CmdGet) return !written[h];
      if (c == cfp_pkg::CmdRead && p != 0 && p <= count) return !written[(h + p - 1) % cap];
      return 1'b0;
    endfunction

    function void note_command(cfp_pkg::cmd_e c, logic [DataW-1:0] d, logic [CapW-1:0] p);
      fifo_result_t r;
      int unsigned  cap;
      int unsigned  h;
      int unsigned  idx;
      cap = eff_cap();
      h = head_idx % cap;
      r.status = cfp_pkg::StOk;
      r.item = '0;
      r.occ = '0;
      words_in++;
      unique case (c)
        cfp_pkg::CmdPut: begin
          if (count >= cap) begin
            r.status = cfp_pkg::StFull;
          end else begin
            idx = (h + count) % cap;
            ring[idx] = d & width_mask();
            written[idx] = 1'b1;
            count++;
          end
          r.occ = CapW'(count);
        end
        cfp_pkg::CmdGet: begin
          if (count == 0) begin
            r.status = cfp_pkg::StEmpty;
          end else begin
            r.item = ring[h] & width_mask();
            h++;
            if (h >= cap) h = 0;
            head_idx = h;
            count--;
          end
          r.occ = CapW'(count);
        end
        cfp_pkg::CmdRead: begin
          if (count == 0) r.status = cfp_pkg::StEmpty;
          else if (p == 0 || p > count) r.status = cfp_pkg::StBadPos;
          else r.item = ring[(h + p - 1) % cap] & width_mask();
          r.occ = CapW'(count);
        end
        cfp_pkg::CmdFlush: begin
          r.occ = CapW'(count);
          head_idx = 0;
          count = 0;
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(cfp_pkg::status_e st, logic [DataW-1:0] item,
                               logic [CapW-1:0] occ);
      fifo_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word: status %0d item %h occupancy %0d",
                 $time, st, item, occ);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      status_seen[e.status]++;
      if (st !== e.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (item !== e.item) begin
        $display("%0t: item mismatch: expected %h actual %h", $time, e.item, item);
        errors++;
      end
      if (occ !== e.occ) begin
        $display("%0t: occupancy mismatch: expected %0d actual %0d", $time, e.occ, occ);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i        = '0;
  logic [DataW-1:0]    data_i       = '0;
  logic [CapW-1:0]     position_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [DataW-1:0]    item_out_o;
  logic [CapW-1:0]     occupancy_o;

  fifo_scoreboard sb;
  bit             quiet = 1'b0;

  circular_fifo_with_peek i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .data_i      (data_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .item_out_o  (item_out_o),
    .occupancy_o (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(cfp_pkg::status_e'(status_o), item_out_o, occupancy_o);
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 6);
  end

  task automatic send_word(input cfp_pkg::cmd_e c, input logic [DataW-1:0] d,
                           input logic [CapW-1:0] p);
    in_valid_i <= 1'b1;
    cmd_i <= c;
    data_i <= d;
    position_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c, d, p);
  endtask

  task automatic maybe_pause();
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned cap, input int unsigned nbytes);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= cfp_pkg::CfgCapacity;
    cfg_data_i <= CfgDataW'(cap);
    @(posedge clk_i);
    sb.write_reg(cfp_pkg::CfgCapacity, CfgDataW'(cap));
    cfg_index_i <= cfp_pkg::CfgItemBytes;
    cfg_data_i <= CfgDataW'(nbytes);
    @(posedge clk_i);
    sb.write_reg(cfp_pkg::CfgItemBytes, CfgDataW'(nbytes));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input int unsigned put_w);
    cfp_pkg::cmd_e    c;
    logic [DataW-1:0] d;
    logic [CapW-1:0]  p;
    int unsigned      r;
    int unsigned      n;
    r = $urandom_range(99);
    if (r < put_w) c = cfp_pkg::CmdPut;
    else if (r < put_w + (99 - put_w) / 2) c = cfp_pkg::CmdGet;
    else if (r < 99) c = cfp_pkg::CmdRead;
    else c = cfp_pkg::CmdFlush;
    d = {$urandom, $urandom};
    r = $urandom_range(9);
    if (r == 0) d = '0;
    else if (r == 1) d = '1;
    n = sb.count;
    r = $urandom_range(9);
    if (r == 0) p = '0;
    else if (r == 1) p = CapW'($urandom);
    else if (r == 2) p = CapW'(n + 1);
    else p = (n == 0) ? CapW'(1) : CapW'($urandom_range(n, 1));
    if (sb.touches_unwritten(c, p)) c = cfp_pkg::CmdPut;
    send_word(c, d, p);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(cfp_pkg::CmdGet, '1, 9'd1);
    send_word(cfp_pkg::CmdRead, '0, 9'd1);
    send_word(cfp_pkg::CmdFlush, '0, '0);
    send_word(cfp_pkg::CmdPut, '1, '0);
    send_word(cfp_pkg::CmdPut, '0, '1);
    send_word(cfp_pkg::CmdPut, 64'h0123_4567_89ab_cdef, '0);
    send_word(cfp_pkg::CmdRead, '0, 9'd0);
    send_word(cfp_pkg::CmdRead, '0, 9'd1);
    send_word(cfp_pkg::CmdRead, '0, 9'd3);
    send_word(cfp_pkg::CmdRead, '0, 9'd4);
    send_word(cfp_pkg::CmdRead, '0, 9'h100);
    send_word(cfp_pkg::CmdRead, '0, 9'h1ff);
    send_word(cfp_pkg::CmdGet, '0, '0);
    send_word(cfp_pkg::CmdFlush, '0, '0);

    set_config(2, 1);
    send_word(cfp_pkg::CmdPut, 64'hfedc_ba98_7654_3210, '0);
    send_word(cfp_pkg::CmdPut, '1, '0);
    send_word(cfp_pkg::CmdPut, 64'h5a5a, '0);
    send_word(cfp_pkg::CmdRead, '0, 9'd2);
    send_word(cfp_pkg::CmdGet, '0, '0);
    send_word(cfp_pkg::CmdGet, '0, '0);
    send_word(cfp_pkg::CmdGet, '0, '0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_config(PhaseCap[ph], PhaseBytes[ph]);
      quiet = (ph == 2);
      for (int i = 0; i < PhaseItems[ph]; i++) begin
        maybe_pause();
        send_random(PhasePut[ph]);
        if (ph == 5 && i == 60) drain_results();
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d command words over %0d register settings.", sb.words_in, NumPhases + 2);
    $display("Results by status: %0d ok, %0d full, %0d empty, %0d bad position.",
             sb.status_seen[cfp_pkg::StOk], sb.status_seen[cfp_pkg::StFull],
             sb.status_seen[cfp_pkg::StEmpty], sb.status_seen[cfp_pkg::StBadPos]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> circular_fifo_with_peek.f
rtl/core/cfp_pkg.sv
rtl/core/cfp_ram.sv
rtl/core/circular_fifo_with_peek.sv
tb/sv/circular_fifo_with_peek_test.sv
